// ===== rtl/ramcf_pkg.sv =====
// ----------------------------------------------------------------------------
// ramcf_pkg
// Shared types, constants and the control program of the ring automaton
// cycle finder.
// ----------------------------------------------------------------------------
package ramcf_pkg;

  localparam int RULE_W = 8;   // Wolfram rule code
  localparam int CNT_W  = 5;   // cell count field
  localparam int LEN_W  = 17;  // result field

  localparam logic [CNT_W-1:0] N_MIN = CNT_W'(3);

  // one entry of the combined visited / current-path map
  typedef struct packed {
    logic path;
    logic visited;
  } map_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_NEWSTART,
    ST_WALK,
    ST_DECIDE,
    ST_BACK,
    ST_BEST,
    ST_PROBE,
    ST_CPATH,
    ST_NEXT,
    ST_DONE
  } step_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_NO_INPUT,
    C_CLEAR_DONE,
    C_SCAN_DONE,
    C_VISITED,
    C_NOT_HIT,
    C_TRACE_AT_WALK,
    C_NOT_PATH,
    C_OUT_FULL
  } cond_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLEAR,
    OP_INIT,
    OP_SETUP,
    OP_WALK,
    OP_BACK,
    OP_BEST,
    OP_PROBE,
    OP_CPATH,
    OP_ADVANCE,
    OP_EMIT
  } op_t;

  // control word: when cond holds, jump to jmp and skip op (latch_hit still applies);
  // otherwise run op and go to nxt
  typedef struct packed {
    cond_t cond;
    step_t jmp;
    step_t nxt;
    op_t   op;
    logic  latch_hit;
  } ctl_t;

  typedef struct packed {
    op_t  op;
    logic latch_hit;
  } cmd_t;

  typedef struct packed {
    logic no_input;
    logic clear_done;
    logic scan_done;
    logic visited;
    logic not_hit;
    logic trace_at_walk;
    logic not_path;
    logic out_full;
  } stat_t;

  function automatic ctl_t prog_word(input step_t s);
    ctl_t w;
    w = '{cond: C_NEVER, jmp: ST_IDLE, nxt: ST_IDLE, op: OP_NONE, latch_hit: 1'b0};
    case (s)
      ST_IDLE:     w = '{C_NO_INPUT,      ST_IDLE,     ST_CLEAR,    OP_ACCEPT,  1'b0};
      ST_CLEAR:    w = '{C_CLEAR_DONE,    ST_INIT,     ST_CLEAR,    OP_CLEAR,   1'b0};
      ST_INIT:     w = '{C_NEVER,         ST_IDLE,     ST_NEWSTART, OP_INIT,    1'b0};
      ST_NEWSTART: w = '{C_SCAN_DONE,     ST_DONE,     ST_WALK,     OP_SETUP,   1'b0};
      ST_WALK:     w = '{C_VISITED,       ST_DECIDE,   ST_WALK,     OP_WALK,    1'b1};
      ST_DECIDE:   w = '{C_NOT_HIT,       ST_PROBE,    ST_BACK,     OP_NONE,    1'b0};
      ST_BACK:     w = '{C_TRACE_AT_WALK, ST_BEST,     ST_BACK,     OP_BACK,    1'b0};
      ST_BEST:     w = '{C_NEVER,         ST_IDLE,     ST_PROBE,    OP_BEST,    1'b0};
      ST_PROBE:    w = '{C_NEVER,         ST_IDLE,     ST_CPATH,    OP_PROBE,   1'b0};
      ST_CPATH:    w = '{C_NOT_PATH,      ST_NEXT,     ST_CPATH,    OP_CPATH,   1'b0};
      ST_NEXT:     w = '{C_NEVER,         ST_IDLE,     ST_NEWSTART, OP_ADVANCE, 1'b0};
      ST_DONE:     w = '{C_OUT_FULL,      ST_DONE,     ST_IDLE,     OP_EMIT,    1'b0};
      default:     w = '{C_NEVER,         ST_IDLE,     ST_IDLE,     OP_NONE,    1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ring_automaton_max_cycle_finder.sv =====
// ----------------------------------------------------------------------------
// ring_automaton_max_cycle_finder
// Longest state cycle of an elementary cellular automaton on a ring.
// ----------------------------------------------------------------------------
// A request (rule, cell_count) enters on in_valid / in_stall; the block
// answers with one max_cycle_length on out_valid / out_stall. A cell_count
// below 3 or above MAX_CELLS is clamped. Only one request is worked at a
// time: in_stall is low only while the sequencer is idle.
// Each request first clears the visited / path map. It then walks from
// every start state with the top bit clear: each reachable state is
// stepped once forward and once on the backtrack or path clear, plus
// the setup, decide, probe and advance steps of each start. The result
// sits in an output register, so a stalled receiver holds it while the
// next request is already taken and run; the sequencer waits only when
// it must hand over a second result.
// Reset returns the sequencer to idle and drops any pending result; map
// contents are rebuilt on every request.
// ----------------------------------------------------------------------------
module ring_automaton_max_cycle_finder
  import ramcf_pkg::*;
#(
  parameter int MAX_CELLS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RULE_W-1:0] rule,
  input  logic [CNT_W-1:0]  cell_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LEN_W-1:0]  max_cycle_length
);

  cmd_t                 cmd;
  stat_t                stat;
  logic                 ready;
  logic                 map_we;
  logic [MAX_CELLS-1:0] map_waddr;
  map_t                 map_wdata;
  logic [MAX_CELLS-1:0] map_raddr;
  map_t                 map_rdata;

  assign in_stall = !ready;

  ramcf_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .stat  (stat),
    .cmd   (cmd),
    .ready (ready)
  );

  ramcf_dp #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .in_valid         (in_valid),
    .rule             (rule),
    .cell_count       (cell_count),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .max_cycle_length (max_cycle_length),
    .stat             (stat),
    .map_we           (map_we),
    .map_waddr        (map_waddr),
    .map_wdata        (map_wdata),
    .map_raddr        (map_raddr),
    .map_rdata        (map_rdata)
  );

  ramcf_ram #(
    .WIDTH ($bits(map_t)),
    .DEPTH (2 ** MAX_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // an accepted request moves the sequencer out of idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !ready)
    else $error("sequencer stayed idle after accepting a request");

  // never overwrite a result the receiver is still stalling
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |-> !(out_valid && out_stall))
    else $error("result emitted over a stalled result");

  // emitting a result shows it and returns to idle
  a_emit_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |=> out_valid && ready)
    else $error("emit did not present the result and return to idle");

  // map is only written while a request is in progress
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    map_we |-> !ready)
    else $error("map written while idle");

endmodule

// ===== rtl/ramcf_ram.sv =====
// ----------------------------------------------------------------------------
// ramcf_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the new data.
// ----------------------------------------------------------------------------
module ramcf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ramcf_seq.sv =====
// ----------------------------------------------------------------------------
// ramcf_seq
// Step counter and program table; picks the jump condition from the
// datapath status and issues one command per cycle.
// ----------------------------------------------------------------------------
module ramcf_seq
  import ramcf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  ready
);

  step_t pc;
  step_t pc_next;
  ctl_t  word;
  logic  cond_true;

  assign word = prog_word(pc);

  always_comb begin
    case (word.cond)
      C_NEVER:         cond_true = 1'b0;
      C_NO_INPUT:      cond_true = stat.no_input;
      C_CLEAR_DONE:    cond_true = stat.clear_done;
      C_SCAN_DONE:     cond_true = stat.scan_done;
      C_VISITED:       cond_true = stat.visited;
      C_NOT_HIT:       cond_true = stat.not_hit;
      C_TRACE_AT_WALK: cond_true = stat.trace_at_walk;
      C_NOT_PATH:      cond_true = stat.not_path;
      C_OUT_FULL:      cond_true = stat.out_full;
      default:         cond_true = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    pc_next = cond_true ? word.jmp : word.nxt;
  end

  // outputs
  always_comb begin
    cmd.op        = cond_true ? OP_NONE : word.op;
    cmd.latch_hit = word.latch_hit;
    ready         = (pc == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/ramcf_dp.sv =====
// ----------------------------------------------------------------------------
// ramcf_dp
// Datapath: request and result registers, walk / trace states, counters,
// the automaton step logic and the map port drive.
// ----------------------------------------------------------------------------
module ramcf_dp
  import ramcf_pkg::*;
#(
  parameter int MAX_CELLS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic                 in_valid,
  input  logic [RULE_W-1:0]    rule,
  input  logic [CNT_W-1:0]     cell_count,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [LEN_W-1:0]     max_cycle_length,
  output stat_t                stat,
  output logic                 map_we,
  output logic [MAX_CELLS-1:0] map_waddr,
  output map_t                 map_wdata,
  output logic [MAX_CELLS-1:0] map_raddr,
  input  map_t                 map_rdata
);

  localparam int W  = MAX_CELLS;
  localparam int IW = $clog2(W);
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_CELLS);

  logic [RULE_W-1:0] rule_q;
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  n_clamp;
  logic [W-1:0]      walk;
  logic [W-1:0]      trace;
  logic [W:0]        start;
  logic [W:0]        run;
  logic [W:0]        best;
  logic              hit;
  logic [LEN_W-1:0]  res;
  logic [W-1:0]      walk_nx;
  logic [W-1:0]      trace_nx;
  logic [W:0]        all_states;
  logic [W:0]        half_states;

  // one automaton step on an n-cell ring; left neighbor is the higher bit
  function automatic logic [W-1:0] ca_next(input logic [RULE_W-1:0] r,
                                           input logic [CNT_W-1:0]  n,
                                           input logic [W-1:0]      s);
    logic [W-1:0]  lv;
    logic [W-1:0]  rv;
    logic [W-1:0]  o;
    logic [IW-1:0] top;
    logic [2:0]    sel;
    lv  = s >> 1;
    rv  = s << 1;
    top = IW'(n - 1'b1);
    o   = '0;
    for (int i = 0; i < W; i++) begin
      sel = {lv[i], s[i], rv[i]};
      if (i == int'(n) - 1) sel[2] = s[0];
      if (i == 0) sel[0] = s[top];
      if (i < int'(n)) o[i] = r[sel];
    end
    return o;
  endfunction

  always_comb begin
    if (cell_count < N_MIN) begin
      n_clamp = N_MIN;
    end else if (cell_count > N_MAX) begin
      n_clamp = N_MAX;
    end else begin
      n_clamp = cell_count;
    end
  end

  assign walk_nx     = ca_next(rule_q, n_q, walk);
  assign trace_nx    = ca_next(rule_q, n_q, trace);
  assign all_states  = {{W{1'b0}}, 1'b1} << n_q;
  assign half_states = {{W{1'b0}}, 1'b1} << (n_q - 1'b1);

  always_comb begin
    stat.no_input      = !in_valid;
    stat.clear_done    = (start == all_states);
    stat.scan_done     = (start == half_states);
    stat.visited       = map_rdata.visited;
    stat.not_hit       = !hit;
    stat.trace_at_walk = (trace == walk);
    stat.not_path      = !map_rdata.path;
    stat.out_full      = out_valid && out_stall;
  end

  // map port drive
  always_comb begin
    map_we    = 1'b0;
    map_waddr = walk;
    map_wdata = '{path: 1'b0, visited: 1'b0};
    map_raddr = walk;
    case (cmd.op)
      OP_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = start[W-1:0];
      end
      OP_SETUP: begin
        map_raddr = start[W-1:0];
      end
      OP_WALK: begin
        map_we    = 1'b1;
        map_wdata = '{path: 1'b1, visited: 1'b1};
        map_raddr = walk_nx;
      end
      OP_BACK: begin
        map_we    = 1'b1;
        map_waddr = trace;
        map_wdata = '{path: 1'b0, visited: 1'b1};
      end
      OP_PROBE: begin
        map_raddr = trace;
      end
      OP_CPATH: begin
        map_we    = 1'b1;
        map_waddr = trace;
        map_wdata = '{path: 1'b0, visited: 1'b1};
        map_raddr = trace_nx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.op == OP_EMIT) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_hit) hit <= map_rdata.path;
    case (cmd.op)
      OP_ACCEPT: begin
        rule_q <= rule;
        n_q    <= n_clamp;
        start  <= '0;
        best   <= '0;
      end
      OP_CLEAR:   start <= start + 1'b1;
      OP_INIT:    start <= '0;
      OP_SETUP: begin
        walk  <= start[W-1:0];
        trace <= start[W-1:0];
        run   <= '0;
      end
      OP_WALK: begin
        run  <= run + 1'b1;
        walk <= walk_nx;
      end
      OP_BACK: begin
        run   <= run - 1'b1;
        trace <= trace_nx;
      end
      OP_BEST: begin
        if (run > best) best <= run;
      end
      OP_CPATH:   trace <= trace_nx;
      OP_ADVANCE: start <= start + 1'b1;
      OP_EMIT:    res   <= LEN_W'(best);
      default: ;
    endcase
  end

  assign max_cycle_length = res;

endmodule
